### hdl/prtm_pkg.sv
// ----------------------------------------------------------------------------
// prtm_pkg - shared types and constants of the protocol traffic rate meter
// Word formats between front, queue, back end and mean pipeline.
// ----------------------------------------------------------------------------
package prtm_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int LEN_W           = 16;
  localparam int OUT_W           = 32;
  localparam int SUM_W           = OUT_W + 2;   // sum of three 32-bit totals
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // operation codes of the input word
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // floor(s / 3) = (s * RECIP3) >> RECIP3_SHIFT for s < 2**34
  localparam int          RECIP3_W     = 36;
  localparam int          RECIP3_SHIFT = 37;
  localparam logic [35:0] RECIP3       = 36'hA_AAAA_AAAB;

  // classified word, front to back
  typedef struct packed {
    logic             is_tick;
    logic             is_tcp;
    logic             is_udp;
    logic [LEN_W-1:0] len;
  } item_t;

  // closed interval, back end to mean pipeline
  typedef struct packed {
    logic [OUT_W-1:0] total;
    logic [OUT_W-1:0] tcp;
    logic [OUT_W-1:0] udp;
    logic [SUM_W-1:0] sum;
    logic             ready;
  } tick_t;

endpackage

### hdl/protocol_traffic_rate_meter.sv
// ----------------------------------------------------------------------------
// protocol_traffic_rate_meter - per-interval TCP/UDP/total byte meter
//
// Input channel (in_valid / in_stall): one word per packet descriptor
// (in_operation = 0, protocol byte and length) or per interval tick
// (in_operation = 1). Packets add their length to saturating counters for
// all traffic, TCP and UDP; they give no result word.
// Output channel (out_valid / out_stall): one word per tick with the three
// interval byte counts, clipped to 32 bits, and from the third tick on the
// shortfall of the truncated three-interval mean below cfg rate limit.
// Configuration: cfg_wr_en / cfg_wr_data write the rate limit; write only
// while no tick is in flight.
// Throughput: one word per cycle, packets and ticks alike, while out_stall is low.
// Path: a tick passes the front register and the queue, then four
// registers after the back end (capture, two for the reciprocal multiply,
// and the output register, which takes the shortfall).
// Reset: counters, history, tick count and rate limit clear; queue empties.
// Output stall: the result holds; packets still drain into the counters,
// ticks wait at the queue head; once the four-word queue and the front
// register are full, in_stall rises.
// ----------------------------------------------------------------------------
module protocol_traffic_rate_meter #(
  parameter int COUNT_WIDTH = prtm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [7:0]                       in_protocol,
  input  logic [prtm_pkg::LEN_W-1:0]       in_length,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [prtm_pkg::OUT_W-1:0]       out_all_octets,
  output logic [prtm_pkg::OUT_W-1:0]       out_tcp_octets,
  output logic [prtm_pkg::OUT_W-1:0]       out_udp_octets,
  output logic signed [prtm_pkg::OUT_W:0]  out_shortfall,
  output logic                             out_mean_ready,
  input  logic                             cfg_wr_en,
  input  logic [prtm_pkg::OUT_W-1:0]       cfg_wr_data
);

  logic                       push, q_full, q_empty, pop, advance, tick_valid;
  prtm_pkg::item_t            push_item, head;
  prtm_pkg::tick_t            tick;
  logic [prtm_pkg::OUT_W-1:0] rate_limit_r;

  // rate limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_limit_r <= '0;
    end else if (cfg_wr_en) begin
      rate_limit_r <= cfg_wr_data;
    end
  end

  prtm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_protocol  (in_protocol),
    .in_length    (in_length),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  prtm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  prtm_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (q_empty),
    .head       (head),
    .pop        (pop),
    .advance    (advance),
    .tick_valid (tick_valid),
    .tick       (tick)
  );

  prtm_mean u_mean (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_valid     (tick_valid),
    .tick           (tick),
    .advance        (advance),
    .rate_limit     (rate_limit_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_all_octets (out_all_octets),
    .out_tcp_octets (out_tcp_octets),
    .out_udp_octets (out_udp_octets),
    .out_shortfall  (out_shortfall),
    .out_mean_ready (out_mean_ready)
  );

endmodule

### hdl/prtm_front.sv
// ----------------------------------------------------------------------------
// prtm_front - input register and protocol classifier
// Takes one word per cycle while in_stall is low and presents it, decoded, to the queue.
// ----------------------------------------------------------------------------
module prtm_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_operation,
  input  logic [7:0]               in_protocol,
  input  logic [prtm_pkg::LEN_W-1:0] in_length,
  output logic                     push,
  output prtm_pkg::item_t          push_item,
  input  logic                     q_full
);

  logic            valid_r, valid_nxt;
  prtm_pkg::item_t item_r, item_nxt;
  logic            accept;

  assign in_stall  = valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = valid_r && !q_full;
  assign push_item = item_r;

  always_comb begin
    item_nxt.is_tick = (in_operation == prtm_pkg::OP_TICK);
    item_nxt.is_tcp  = (in_operation == prtm_pkg::OP_PACKET) &&
                       (in_protocol == prtm_pkg::PROTO_TCP);
    item_nxt.is_udp  = (in_operation == prtm_pkg::OP_PACKET) &&
                       (in_protocol == prtm_pkg::PROTO_UDP);
    item_nxt.len     = in_length;
    valid_nxt        = accept ? 1'b1 : (push ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

### hdl/prtm_queue.sv
// ----------------------------------------------------------------------------
// prtm_queue - short word queue between front and back end
// Lets the front keep taking words while the back end waits on the output.
// ----------------------------------------------------------------------------
module prtm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  prtm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output prtm_pkg::item_t head
);

  localparam int PTR_W = $clog2(prtm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(prtm_pkg::QUEUE_DEPTH + 1);

  prtm_pkg::item_t   mem [prtm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_W'(prtm_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/prtm_back.sv
// ----------------------------------------------------------------------------
// prtm_back - interval byte counters and tick history
// Packets update the saturating counters; a tick closes the interval.
// ----------------------------------------------------------------------------
module prtm_back #(
  parameter int COUNT_WIDTH = prtm_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty,
  input  prtm_pkg::item_t head,
  output logic            pop,
  input  logic            advance,
  output logic            tick_valid,
  output prtm_pkg::tick_t tick
);

  localparam int OW = prtm_pkg::OUT_W;
  localparam int SW = prtm_pkg::SUM_W;

  logic [COUNT_WIDTH-1:0] all_r, tcp_r, udp_r;
  logic [COUNT_WIDTH-1:0] all_nxt, tcp_nxt, udp_nxt;
  logic [OW-1:0]          prev0_r, prev1_r;
  logic [1:0]             ticks_r, ticks_nxt;
  logic                   do_pkt, do_tick;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(
    input logic [COUNT_WIDTH-1:0]     acc,
    input logic [prtm_pkg::LEN_W-1:0] len
  );
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, acc} + (COUNT_WIDTH+1)'(len);
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  // clip a counter to the 32-bit result field
  function automatic logic [OW-1:0] clip(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    return (e > 64'h0000_0000_FFFF_FFFF) ? '1 : e[OW-1:0];
  endfunction

  // ticks wait for pipeline space, packets never do
  assign pop     = !empty && (!head.is_tick || advance);
  assign do_pkt  = pop && !head.is_tick;
  assign do_tick = pop && head.is_tick;

  always_comb begin
    all_nxt   = all_r;
    tcp_nxt   = tcp_r;
    udp_nxt   = udp_r;
    ticks_nxt = ticks_r;
    if (do_pkt) begin
      all_nxt = sat_add(all_r, head.len);
      if (head.is_tcp) begin
        tcp_nxt = sat_add(tcp_r, head.len);
      end
      if (head.is_udp) begin
        udp_nxt = sat_add(udp_r, head.len);
      end
    end else if (do_tick) begin
      all_nxt = '0;
      tcp_nxt = '0;
      udp_nxt = '0;
      if (ticks_r != 2'd3) begin
        ticks_nxt = ticks_r + 2'd1;
      end
    end
    tick.total = clip(all_r);
    tick.tcp   = clip(tcp_r);
    tick.udp   = clip(udp_r);
    tick.sum   = SW'(prev0_r) + SW'(prev1_r) + SW'(tick.total);
    tick.ready = (ticks_r == 2'd3) || (ticks_r == 2'd2);
  end

  assign tick_valid = do_tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_r   <= '0;
      tcp_r   <= '0;
      udp_r   <= '0;
      prev0_r <= '0;
      prev1_r <= '0;
      ticks_r <= '0;
    end else begin
      all_r   <= all_nxt;
      tcp_r   <= tcp_nxt;
      udp_r   <= udp_nxt;
      ticks_r <= ticks_nxt;
      if (do_tick) begin
        prev0_r <= prev1_r;
        prev1_r <= tick.total;
      end
    end
  end

endmodule

### hdl/prtm_mean.sv
// ----------------------------------------------------------------------------
// prtm_mean - three-interval mean, shortfall and output register
// Divide by three as a reciprocal multiply split over two stages.
// ----------------------------------------------------------------------------
module prtm_mean (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick_valid,
  input  prtm_pkg::tick_t             tick,
  output logic                        advance,
  input  logic [prtm_pkg::OUT_W-1:0]  rate_limit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [prtm_pkg::OUT_W-1:0]  out_all_octets,
  output logic [prtm_pkg::OUT_W-1:0]  out_tcp_octets,
  output logic [prtm_pkg::OUT_W-1:0]  out_udp_octets,
  output logic signed [prtm_pkg::OUT_W:0] out_shortfall,
  output logic                        out_mean_ready
);

  localparam int OW   = prtm_pkg::OUT_W;
  localparam int SW   = prtm_pkg::SUM_W;
  localparam int LO_W = SW / 2;
  localparam int MW   = prtm_pkg::RECIP3_W;
  localparam int PP_W = LO_W + MW;
  localparam int PR_W = SW + MW;
  localparam int SH   = prtm_pkg::RECIP3_SHIFT;

  logic            s1_valid_r, s2_valid_r, s3_valid_r, o_valid_r;
  prtm_pkg::tick_t s1_r, s2_r, s3_r;
  logic [PP_W-1:0] s2_plo_r;
  logic [OW-1:0]   s3_q_r;
  logic [PP_W-1:0] plo_nxt;
  logic [PR_W-1:0] prod_nxt;
  logic [OW-1:0]   q_nxt;
  logic [OW:0]     short_nxt;

  logic [OW-1:0]   o_total_r, o_tcp_r, o_udp_r;
  logic [OW:0]     o_short_r;
  logic            o_ready_r;

  assign advance = !(o_valid_r && out_stall);

  always_comb begin
    plo_nxt  = PP_W'(s1_r.sum[LO_W-1:0]) * PP_W'(prtm_pkg::RECIP3);
    prod_nxt = PR_W'(s2_plo_r) +
               (PR_W'(PP_W'(s2_r.sum[SW-1:LO_W]) * PP_W'(prtm_pkg::RECIP3)) << LO_W);
    q_nxt    = prod_nxt[SH+OW-1:SH];
    // shortfall only when the mean is ready and falls below the limit
    if (s3_r.ready && (s3_q_r < rate_limit)) begin
      short_nxt = {1'b0, s3_q_r} - {1'b0, rate_limit};
    end else begin
      short_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= tick_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      o_valid_r  <= s3_valid_r;
    end
    if (advance) begin
      s1_r      <= tick;
      s2_r      <= s1_r;
      s2_plo_r  <= plo_nxt;
      s3_r      <= s2_r;
      s3_q_r    <= q_nxt;
      o_total_r <= s3_r.total;
      o_tcp_r   <= s3_r.tcp;
      o_udp_r   <= s3_r.udp;
      o_short_r <= short_nxt;
      o_ready_r <= s3_r.ready;
    end
  end

  assign out_valid      = o_valid_r;
  assign out_all_octets = o_total_r;
  assign out_tcp_octets = o_tcp_r;
  assign out_udp_octets = o_udp_r;
  assign out_shortfall  = o_short_r;
  assign out_mean_ready = o_ready_r;

endmodule
